// ===== sv/lnp_pkg.sv =====
package lnp_pkg;

  // input command codes
  localparam logic [1:0] CMD_NOTE_ON  = 2'd0;
  localparam logic [1:0] CMD_NOTE_OFF = 2'd1;
  localparam logic [1:0] CMD_CLOCK    = 2'd2;
  localparam logic [1:0] CMD_TICK     = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_NOTE_OFFSET      = 3'd0;
  localparam logic [CFG_IW-1:0] REG_PITCH_STEP       = 3'd1;
  localparam logic [CFG_IW-1:0] REG_TRIG_PULSE_MS    = 3'd2;
  localparam logic [CFG_IW-1:0] REG_CLOCK_PULSE_MS   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_CLOCK_TIMEOUT_MS = 3'd4;
  localparam logic [CFG_IW-1:0] REG_CLOCK_DIVISION   = 3'd5;

  // register reset values
  localparam logic [6:0]  RST_NOTE_OFFSET      = 7'd21;
  localparam logic [11:0] RST_PITCH_STEP       = 12'd35;
  localparam logic [7:0]  RST_TRIG_PULSE_MS    = 8'd20;
  localparam logic [7:0]  RST_CLOCK_PULSE_MS   = 8'd20;
  localparam logic [9:0]  RST_CLOCK_TIMEOUT_MS = 10'd300;
  localparam logic [6:0]  RST_CLOCK_DIVISION   = 7'd24;

  // DAC word fields
  localparam logic [3:0]  VEL_WORD_HEAD   = 4'h9;     // channel B, gain 2X
  localparam logic [3:0]  PITCH_WORD_HEAD = 4'h3;     // channel A, gain 1X
  localparam logic [11:0] DAC_VALUE_MASK  = 12'h0FFF;

  localparam logic [10:0] SINCE_MAX = 11'd2047;

  // decoded operation carried through the queue
  typedef enum logic [1:0] {
    OP_NOTE_ON  = 2'd0,
    OP_NOTE_OFF = 2'd1,
    OP_CLOCK    = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [6:0] note;
    logic [6:0] velocity;
  } item_t;

  typedef struct packed {
    logic [6:0]  note_offset;
    logic [11:0] pitch_step;
    logic [7:0]  trig_pulse_ms;
    logic [7:0]  clock_pulse_ms;
    logic [9:0]  clock_timeout_ms;
    logic [6:0]  clock_division;
  } cfg_t;

  // queue depth between front and back
  localparam int unsigned QDEPTH = 2;

endpackage

// ===== sv/lnp_front.sv =====
module lnp_front #(
  parameter int unsigned NOTE_COUNT = 88
) (
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_cmd,
  input  logic [6:0]       in_note,
  input  logic [6:0]       in_velocity,
  input  logic             q_full,
  output logic             q_push,
  output lnp_pkg::item_t   q_item
);
  import lnp_pkg::*;

  localparam logic [7:0] NOTE_LIM = 8'(NOTE_COUNT);

  logic is_note;
  logic ignored;

  // notes out of range are taken and dropped
  assign is_note  = (in_cmd == CMD_NOTE_ON) || (in_cmd == CMD_NOTE_OFF);
  assign ignored  = is_note && ({1'b0, in_note} >= NOTE_LIM);
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && !ignored;

  // classify: zero velocity or note off both clear the key
  always_comb begin
    q_item.note     = in_note;
    q_item.velocity = in_velocity;
    case (in_cmd)
      CMD_NOTE_ON: begin
        q_item.op = (in_velocity != 7'd0) ? OP_NOTE_ON : OP_NOTE_OFF;
      end
      CMD_NOTE_OFF: begin
        q_item.op = OP_NOTE_OFF;
      end
      CMD_CLOCK: begin
        q_item.op = OP_CLOCK;
      end
      default: begin
        q_item.op = OP_TICK;
      end
    endcase
  end

endmodule

// ===== sv/lnp_fifo.sv =====
module lnp_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  lnp_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output logic            pop_valid,
  output lnp_pkg::item_t  pop_item
);
  import lnp_pkg::*;

  localparam int unsigned PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);

  item_t         slot_r [QDEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full      = (count_r == CW'(QDEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_item  = slot_r[rd_ptr_r];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== sv/lnp_back.sv =====
module lnp_back #(
  parameter int unsigned ORDER_DEPTH = 20,
  parameter int unsigned NOTE_COUNT  = 88
) (
  input  logic            clk,
  input  logic            rst_n,
  input  lnp_pkg::cfg_t   cfg,
  input  logic            q_valid,
  input  lnp_pkg::item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_dac_valid,
  output logic [15:0]     out_dac_word,
  output logic            out_gate_level,
  output logic            out_trig_level,
  output logic            out_clock_level,
  output logic            out_last
);
  import lnp_pkg::*;

  localparam int unsigned PW = $clog2(ORDER_DEPTH);
  localparam int unsigned NW = (NOTE_COUNT > 1) ? $clog2(NOTE_COUNT) : 1;
  localparam logic [7:0]  NOTE_LIM = 8'(NOTE_COUNT);
  localparam logic [PW-1:0] POS_LAST = PW'(ORDER_DEPTH - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // voice state
  logic [NOTE_COUNT-1:0] held_r, held_nxt;
  logic [6:0]    ring_r [ORDER_DEPTH];
  logic          ring_we;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          gate_r, gate_nxt;
  logic          trig_r, trig_nxt;
  logic [7:0]    trig_el_r, trig_el_nxt;
  logic          clk_out_r, clk_out_nxt;
  logic [7:0]    clk_el_r, clk_el_nxt;
  logic [6:0]    div_r, div_nxt;
  logic [10:0]   since_r, since_nxt;

  // scan state
  logic [PW-1:0] scan_idx_r, scan_idx_nxt;
  logic [PW-1:0] scan_cnt_r, scan_cnt_nxt;
  logic          found_r, found_nxt;
  logic [6:0]    found_note_r, found_note_nxt;

  // output word register
  logic          ov_r, ov_nxt;
  logic          o_dv_r, o_dv_nxt;
  logic [15:0]   o_word_r, o_word_nxt;
  logic          o_gate_r, o_gate_nxt;
  logic          o_trig_r, o_trig_nxt;
  logic          o_clk_r, o_clk_nxt;
  logic          o_last_r, o_last_nxt;

  logic          slot_free;
  logic [6:0]    ring_rd;
  logic          hit;
  logic [PW-1:0] pos_inc;
  logic [11:0]   diff;
  logic [23:0]   prod;
  logic [8:0]    trig_sum, clk_sum;
  logic [7:0]    div_sum;
  logic [6:0]    div_base;

  assign slot_free = !ov_r || out_ready;
  assign ring_rd   = ring_r[scan_idx_r];
  assign hit       = ({1'b0, ring_rd} < NOTE_LIM) && held_r[ring_rd[NW-1:0]];
  assign pos_inc   = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
  assign diff      = {5'd0, found_note_r} - {5'd0, cfg.note_offset};
  assign prod      = diff * cfg.pitch_step;
  assign trig_sum  = {1'b0, trig_el_r} + 9'd1;
  assign clk_sum   = {1'b0, clk_el_r} + 9'd1;
  assign div_base  = (since_r > {1'b0, cfg.clock_timeout_ms}) ? 7'd0 : div_r;
  assign div_sum   = {1'b0, div_base} + 8'd1;

  assign q_pop = (state_r == ST_IDLE) && q_valid && slot_free;
  assign ring_we = q_pop && (q_item.op == OP_NOTE_ON);

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    pos_nxt        = pos_r;
    gate_nxt       = gate_r;
    trig_nxt       = trig_r;
    trig_el_nxt    = trig_el_r;
    clk_out_nxt    = clk_out_r;
    clk_el_nxt     = clk_el_r;
    div_nxt        = div_r;
    since_nxt      = since_r;
    scan_idx_nxt   = scan_idx_r;
    scan_cnt_nxt   = scan_cnt_r;
    found_nxt      = found_r;
    found_note_nxt = found_note_r;
    ov_nxt         = ov_r && !out_ready;
    o_dv_nxt       = o_dv_r;
    o_word_nxt     = o_word_r;
    o_gate_nxt     = o_gate_r;
    o_trig_nxt     = o_trig_r;
    o_clk_nxt      = o_clk_r;
    o_last_nxt     = o_last_r;

    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_item.op)
            OP_NOTE_ON: begin
              // velocity word first, levels as they stand
              held_nxt[q_item.note[NW-1:0]] = 1'b1;
              pos_nxt      = pos_inc;
              scan_idx_nxt = pos_inc;
              scan_cnt_nxt = '0;
              ov_nxt       = 1'b1;
              o_dv_nxt     = 1'b1;
              o_word_nxt   = {VEL_WORD_HEAD, q_item.velocity, 5'd0};
              o_gate_nxt   = gate_r;
              o_trig_nxt   = trig_r;
              o_clk_nxt    = clk_out_r;
              o_last_nxt   = 1'b0;
              state_nxt    = ST_SCAN;
            end
            OP_NOTE_OFF: begin
              held_nxt[q_item.note[NW-1:0]] = 1'b0;
              scan_idx_nxt = pos_r;
              scan_cnt_nxt = '0;
              state_nxt    = ST_SCAN;
            end
            OP_CLOCK: begin
              since_nxt = '0;
              if (div_base == 7'd0) begin
                clk_out_nxt = 1'b1;
                clk_el_nxt  = '0;
              end
              div_nxt = (div_sum >= {1'b0, cfg.clock_division}) ? 7'd0 : div_sum[6:0];
              ov_nxt     = 1'b1;
              o_dv_nxt   = 1'b0;
              o_word_nxt = '0;
              o_gate_nxt = gate_r;
              o_trig_nxt = trig_r;
              o_clk_nxt  = (div_base == 7'd0) ? 1'b1 : clk_out_r;
              o_last_nxt = 1'b1;
            end
            default: begin
              // millisecond tick: age the pulses and the time since the last clock
              if (since_r != SINCE_MAX) begin
                since_nxt = since_r + 1'b1;
              end
              o_trig_nxt = trig_r;
              o_clk_nxt  = clk_out_r;
              if (trig_r) begin
                if (trig_sum > {1'b0, cfg.trig_pulse_ms}) begin
                  trig_nxt    = 1'b0;
                  trig_el_nxt = '0;
                  o_trig_nxt  = 1'b0;
                end else begin
                  trig_el_nxt = trig_sum[7:0];
                end
              end
              if (clk_out_r) begin
                if (clk_sum > {1'b0, cfg.clock_pulse_ms}) begin
                  clk_out_nxt = 1'b0;
                  clk_el_nxt  = '0;
                  o_clk_nxt   = 1'b0;
                end else begin
                  clk_el_nxt = clk_sum[7:0];
                end
              end
              ov_nxt     = 1'b1;
              o_dv_nxt   = 1'b0;
              o_word_nxt = '0;
              o_gate_nxt = gate_r;
              o_last_nxt = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // newest to oldest, one ring entry a cycle
        if (hit) begin
          found_nxt      = 1'b1;
          found_note_nxt = ring_rd;
          state_nxt      = ST_EMIT;
        end else if (scan_cnt_r == POS_LAST) begin
          found_nxt = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          scan_idx_nxt = (scan_idx_r == '0) ? POS_LAST : scan_idx_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          ov_nxt     = 1'b1;
          o_clk_nxt  = clk_out_r;
          o_last_nxt = 1'b1;
          if (found_r) begin
            gate_nxt    = 1'b1;
            trig_nxt    = 1'b1;
            trig_el_nxt = '0;
            o_dv_nxt    = 1'b1;
            o_word_nxt  = {PITCH_WORD_HEAD, prod[11:0] & DAC_VALUE_MASK};
            o_gate_nxt  = 1'b1;
            o_trig_nxt  = 1'b1;
          end else begin
            gate_nxt   = 1'b0;
            o_dv_nxt   = 1'b0;
            o_word_nxt = '0;
            o_gate_nxt = 1'b0;
            o_trig_nxt = trig_r;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and voice registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      held_r    <= '0;
      pos_r     <= '0;
      gate_r    <= 1'b0;
      trig_r    <= 1'b0;
      trig_el_r <= '0;
      clk_out_r <= 1'b0;
      clk_el_r  <= '0;
      div_r     <= '0;
      since_r   <= SINCE_MAX;
      ov_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      held_r    <= held_nxt;
      pos_r     <= pos_nxt;
      gate_r    <= gate_nxt;
      trig_r    <= trig_nxt;
      trig_el_r <= trig_el_nxt;
      clk_out_r <= clk_out_nxt;
      clk_el_r  <= clk_el_nxt;
      div_r     <= div_nxt;
      since_r   <= since_nxt;
      ov_r      <= ov_nxt;
    end
  end

  // note order ring, cleared to note 0 at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ORDER_DEPTH; i++) begin
        ring_r[i] <= '0;
      end
    end else if (ring_we) begin
      ring_r[pos_inc] <= q_item.note;
    end
  end

  // scan and output payload
  always_ff @(posedge clk) begin
    scan_idx_r   <= scan_idx_nxt;
    scan_cnt_r   <= scan_cnt_nxt;
    found_r      <= found_nxt;
    found_note_r <= found_note_nxt;
    o_dv_r       <= o_dv_nxt;
    o_word_r     <= o_word_nxt;
    o_gate_r     <= o_gate_nxt;
    o_trig_r     <= o_trig_nxt;
    o_clk_r      <= o_clk_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign out_valid       = ov_r;
  assign out_dac_valid   = o_dv_r;
  assign out_dac_word    = o_word_r;
  assign out_gate_level  = o_gate_r;
  assign out_trig_level  = o_trig_r;
  assign out_clock_level = o_clk_r;
  assign out_last        = o_last_r;

endmodule

// ===== sv/last_note_priority_midi_to_cv.sv =====
// Clock and tick words: handled in the back end idle state, result registered on the pop.
// Note words: the key map is updated in the idle state, then the ring is scanned newest
// to oldest, one ring entry a cycle, until a held note is found or all ORDER_DEPTH
// entries are seen; the result goes out when the output slot is free. One event at a time.
// Reset (rst_n low, synchronous): all keys released, ring cleared to note 0,
// out_valid, gate, trigger and clock state low, configuration back to its defaults.
module last_note_priority_midi_to_cv #(
  parameter int unsigned ORDER_DEPTH = 20,
  parameter int unsigned NOTE_COUNT  = 88
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 in_cmd,
  input  logic [6:0]                 in_note,
  input  logic [6:0]                 in_velocity,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       out_dac_valid,
  output logic [15:0]                out_dac_word,
  output logic                       out_gate_level,
  output logic                       out_trig_level,
  output logic                       out_clock_level,
  output logic                       out_last,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lnp_pkg::CFG_IW-1:0] cfg_index,
  input  logic [15:0]                cfg_data
);
  import lnp_pkg::*;

  cfg_t  cfg_r;
  item_t push_item, pop_item;
  logic  q_full, q_push, q_pop, q_valid;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.note_offset      <= RST_NOTE_OFFSET;
      cfg_r.pitch_step       <= RST_PITCH_STEP;
      cfg_r.trig_pulse_ms    <= RST_TRIG_PULSE_MS;
      cfg_r.clock_pulse_ms   <= RST_CLOCK_PULSE_MS;
      cfg_r.clock_timeout_ms <= RST_CLOCK_TIMEOUT_MS;
      cfg_r.clock_division   <= RST_CLOCK_DIVISION;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NOTE_OFFSET:      cfg_r.note_offset      <= cfg_data[6:0];
        REG_PITCH_STEP:       cfg_r.pitch_step       <= cfg_data[11:0];
        REG_TRIG_PULSE_MS:    cfg_r.trig_pulse_ms    <= cfg_data[7:0];
        REG_CLOCK_PULSE_MS:   cfg_r.clock_pulse_ms   <= cfg_data[7:0];
        REG_CLOCK_TIMEOUT_MS: cfg_r.clock_timeout_ms <= cfg_data[9:0];
        REG_CLOCK_DIVISION:   cfg_r.clock_division   <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  lnp_front #(
    .NOTE_COUNT (NOTE_COUNT)
  ) u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_cmd      (in_cmd),
    .in_note     (in_note),
    .in_velocity (in_velocity),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_item      (push_item)
  );

  lnp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_item  (pop_item)
  );

  lnp_back #(
    .ORDER_DEPTH (ORDER_DEPTH),
    .NOTE_COUNT  (NOTE_COUNT)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .q_valid         (q_valid),
    .q_item          (pop_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dac_valid   (out_dac_valid),
    .out_dac_word    (out_dac_word),
    .out_gate_level  (out_gate_level),
    .out_trig_level  (out_trig_level),
    .out_clock_level (out_clock_level),
    .out_last        (out_last)
  );

endmodule
